// ----- src/kif_pkg.sv -----
`timescale 1ns / 1ps
// kif_pkg: shared types and constants of the 3x3 kernel image filter.
// No dependencies; used by the top level, kif_window and kif_filter.

package kif_pkg;

  // Configuration register indexes
  localparam logic [1:0] CFG_FILTER_MODE  = 2'd0;
  localparam logic [1:0] CFG_LINE_WIDTH   = 2'd1;
  localparam logic [1:0] CFG_FRAME_HEIGHT = 2'd2;

  localparam int unsigned CFG_DATA_W   = 12;
  localparam int unsigned LINE_W_BITS  = 11;
  localparam int unsigned HEIGHT_BITS  = 12;
  localparam int unsigned PIX_W        = 8;

  // Box average: floor(sum * 11111 / 100000), the divide done as a
  // reciprocal multiply that is exact for products below 2^25.
  localparam int unsigned BOX_NUM      = 11111;
  localparam int unsigned BOX_RECIP    = 43980466;
  localparam int unsigned BOX_SHIFT    = 42;
  // Divide by 3, exact for dividends below 2048
  localparam int unsigned DIV3_MUL     = 683;
  localparam int unsigned DIV3_SHIFT   = 11;

  typedef enum logic [2:0] {
    MODE_BOX,
    MODE_GAUSS,
    MODE_PREWITT_X,
    MODE_PREWITT_Y,
    MODE_SOBEL_X,
    MODE_SOBEL_Y,
    MODE_LAPLACE,
    MODE_SHARPEN
  } mode_e;

  // What the back end of the filter pipe still has to do with a value
  typedef enum logic [1:0] {
    KIND_PASS,
    KIND_BOX,
    KIND_DIV3
  } kind_e;

  typedef struct packed {
    logic centre_valid;
    logic frame_done;
  } flags_t;

  // 3x3 window, index row*3+col, row 0 oldest, col 0 leftmost
  typedef logic [8:0][PIX_W-1:0] win_t;

endpackage

// ----- src/kif_if.sv -----
`timescale 1ns / 1ps
// kif_pix_if / kif_res_if: valid-ready channels of the kernel image filter.
// Depends on nothing.

interface kif_pix_if;
  logic       valid;
  logic       ready;
  logic [7:0] pixel;

  modport source (output valid, output pixel, input ready);
  modport sink   (input valid, input pixel, output ready);
endinterface

interface kif_res_if;
  logic       valid;
  logic       ready;
  logic [7:0] filtered;
  logic       centre_valid;
  logic       frame_done;

  modport source (output valid, output filtered, output centre_valid,
                  output frame_done, input ready);
  modport sink   (input valid, input filtered, input centre_valid,
                  input frame_done, output ready);
endinterface

// ----- src/kernel_3x3_image_filter.sv -----
`timescale 1ns / 1ps
// kernel_3x3_image_filter: streaming 3x3 box/Gauss/Prewitt/Sobel/Laplace/sharpen filter.
// Depends on kif_pkg, kif_if, kif_window and kif_filter.
//
//   port     | dir | handshake     | carries
//   pix_i    | in  | valid/ready   | pixel[7:0]
//   res_o    | out | valid/ready   | filtered[7:0], centre_valid, frame_done
//   cfg_*    | in  | cfg_we_i only | cfg_idx_i selects mode, line width, height
//
// One pixel per clock sustained while res_o.ready holds; each request gives one
// result, through five register stages (line-store read, window,
// kernel sum, scale multiply, output register).
// The line stores are two RAMs read and written once per pixel; no clearing
// pass after reset, so pixels are taken from the first cycle out of reset.
// A stalled output fills the pipe stage by stage before pix_i.ready drops.

module kernel_3x3_image_filter #(
  parameter int unsigned MAX_WIDTH = 1024
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  kif_pix_if.sink     pix_i,
  kif_res_if.source   res_o,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [11:0] cfg_data_i
);

  kif_pkg::mode_e  mode_q, mode_d;
  logic [10:0]     line_width_q, line_width_d;
  logic [11:0]     frame_height_q, frame_height_d;

  logic            win_valid, win_ready;
  kif_pkg::win_t   win;
  kif_pkg::flags_t win_flags;

  always_comb begin
    mode_d         = mode_q;
    line_width_d   = line_width_q;
    frame_height_d = frame_height_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        kif_pkg::CFG_FILTER_MODE:  mode_d = kif_pkg::mode_e'(cfg_data_i[2:0]);
        kif_pkg::CFG_LINE_WIDTH:   line_width_d = cfg_data_i[10:0];
        kif_pkg::CFG_FRAME_HEIGHT: frame_height_d = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q         <= kif_pkg::MODE_BOX;
      line_width_q   <= 11'd1024;
      frame_height_q <= 12'd1024;
    end else begin
      mode_q         <= mode_d;
      line_width_q   <= line_width_d;
      frame_height_q <= frame_height_d;
    end
  end

  kif_window #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_window (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .line_width_i   (line_width_q),
    .frame_height_i (frame_height_q),
    .pix_i          (pix_i),
    .win_valid_o    (win_valid),
    .win_o          (win),
    .win_flags_o    (win_flags),
    .win_ready_i    (win_ready)
  );

  kif_filter u_filter (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .mode_i      (mode_q),
    .win_valid_i (win_valid),
    .win_i       (win),
    .win_flags_i (win_flags),
    .win_ready_o (win_ready),
    .res_o       (res_o)
  );

endmodule

// ----- src/kif_ram.sv -----
`timescale 1ns / 1ps
// kif_ram: generic simple dual-port RAM, one write and one registered read port.
// Depends on nothing.

module kif_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- src/kif_window.sv -----
`timescale 1ns / 1ps
// kif_window: raster counters, the two line-store RAMs and the 3x3 window.
// Depends on kif_pkg, kif_pix_if and kif_ram.

module kif_window #(
  parameter int unsigned MAX_WIDTH = 1024
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [10:0]         line_width_i,
  input  logic [11:0]         frame_height_i,
  kif_pix_if.sink             pix_i,
  output logic                win_valid_o,
  output kif_pkg::win_t       win_o,
  output kif_pkg::flags_t     win_flags_o,
  input  logic                win_ready_i
);

  localparam int unsigned CW   = $clog2(MAX_WIDTH);
  localparam int unsigned CMPW = (CW + 1 > 12) ? CW + 1 : 12;

  // raster position of the next pixel
  logic [CW-1:0]   col_q, col_d;
  logic [11:0]     row_q, row_d;

  // stage 1: pixel waiting for its line-store reads
  logic            v1_q, v1_d;
  logic [7:0]      px1_q;
  logic [CW-1:0]   c1_q;
  kif_pkg::flags_t fl1_q;

  // stage 2: window holding the request's neighborhood
  logic            v2_q, v2_d;
  kif_pkg::flags_t fl2_q;
  kif_pkg::win_t   win_q, win_d;

  logic            ld1, ld2, acc, shift_en;
  logic [7:0]      mid_rd, top_rd;

  logic [CW:0]     col_inc;
  logic [12:0]     row_inc;
  logic [10:0]     lw_eff;
  logic [11:0]     h_eff;
  logic            row_end, frame_end;
  kif_pkg::flags_t fl_new;

  assign ld2      = !v2_q || win_ready_i;
  assign ld1      = !v1_q || ld2;
  assign acc      = pix_i.valid && ld1;
  assign shift_en = v1_q && ld2;
  assign pix_i.ready = ld1;

  // Row end when col+1 >= max(3, line_width) or col+1 >= MAX_WIDTH
  always_comb begin
    lw_eff    = (line_width_i < 11'd3) ? 11'd3 : line_width_i;
    h_eff     = (frame_height_i < 12'd3) ? 12'd3 : frame_height_i;
    col_inc   = {1'b0, col_q} + (CW + 1)'(1);
    row_inc   = {1'b0, row_q} + 13'd1;
    row_end   = (CMPW'(col_inc) >= CMPW'(lw_eff)) ||
                (CMPW'(col_inc) >= CMPW'(MAX_WIDTH));
    frame_end = row_end && (row_inc >= {1'b0, h_eff});
    fl_new.centre_valid = (row_q >= 12'd2) && (col_q >= CW'(2));
    fl_new.frame_done   = frame_end;
  end

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (acc) begin
      if (row_end) begin
        col_d = '0;
        row_d = frame_end ? 12'd0 : row_inc[11:0];
      end else begin
        col_d = col_inc[CW-1:0];
      end
    end
  end

  always_comb begin
    v1_d = ld1 ? acc : v1_q;
    v2_d = ld2 ? v1_q : v2_q;
  end

  always_comb begin
    win_d = win_q;
    if (shift_en) begin
      for (int r = 0; r < 3; r++) begin
        win_d[r*3]   = win_q[r*3+1];
        win_d[r*3+1] = win_q[r*3+2];
      end
      win_d[2] = top_rd;
      win_d[5] = mid_rd;
      win_d[8] = px1_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
      v1_q  <= 1'b0;
      v2_q  <= 1'b0;
      win_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
      v1_q  <= v1_d;
      v2_q  <= v2_d;
      win_q <= win_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      px1_q <= pix_i.pixel;
      c1_q  <= col_q;
      fl1_q <= fl_new;
    end
    if (shift_en) begin
      fl2_q <= fl1_q;
    end
  end

  // Reads go out with the request; write-back happens as it leaves stage 1.
  // The same column is next read a full row later, after the write.
  kif_ram #(
    .WIDTH (8),
    .DEPTH (MAX_WIDTH)
  ) u_line_a (
    .clk_i   (clk_i),
    .we_i    (shift_en),
    .waddr_i (c1_q),
    .wdata_i (px1_q),
    .re_i    (acc),
    .raddr_i (col_q),
    .rdata_o (mid_rd)
  );

  kif_ram #(
    .WIDTH (8),
    .DEPTH (MAX_WIDTH)
  ) u_line_b (
    .clk_i   (clk_i),
    .we_i    (shift_en),
    .waddr_i (c1_q),
    .wdata_i (mid_rd),
    .re_i    (acc),
    .raddr_i (col_q),
    .rdata_o (top_rd)
  );

  assign win_valid_o = v2_q;
  assign win_o       = win_q;
  assign win_flags_o = fl2_q;

endmodule

// ----- src/kif_filter.sv -----
`timescale 1ns / 1ps
// kif_filter: kernel sums, scaling and output register of the image filter.
// Depends on kif_pkg and kif_res_if.

module kif_filter (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  kif_pkg::mode_e    mode_i,
  input  logic              win_valid_i,
  input  kif_pkg::win_t     win_i,
  input  kif_pkg::flags_t   win_flags_i,
  output logic              win_ready_o,
  kif_res_if.source         res_o
);

  function automatic logic [11:0] abs_diff(input logic [11:0] a, input logic [11:0] b);
    return (a >= b) ? a - b : b - a;
  endfunction

  // stage 3: kernel value, stage 4: first scale multiply, out: final value
  logic            v3_q, v3_d, v4_q, v4_d, vo_q, vo_d;
  logic            ld3, ld4, ldo;
  kif_pkg::kind_e  kind3_d, kind3_q, kind4_q;
  logic [11:0]     val3_d, val3_q;
  logic [24:0]     prod4_d, prod4_q;
  logic [7:0]      filt_d, filt_q;
  kif_pkg::flags_t fl3_q, fl4_q, flo_q;

  logic [11:0]     sum_all, gauss, c9, c10, sharp_diff;
  logic [9:0]      pxp, pxn, pyp, pyn, sxp, sxn, syp, syn;
  logic [11:0]     lap_abs, px_abs, py_abs, sx_abs, sy_abs;
  logic [7:0]      sharp;
  logic [50:0]     box_prod;

  assign ldo = !vo_q || res_o.ready;
  assign ld4 = !v4_q || ldo;
  assign ld3 = !v3_q || ld4;
  assign win_ready_o = ld3;

  always_comb begin
    v3_d = ld3 ? win_valid_i : v3_q;
    v4_d = ld4 ? v3_q : v4_q;
    vo_d = ldo ? v4_q : vo_q;
  end

  // Kernel sums over the window
  always_comb begin
    sum_all = '0;
    for (int i = 0; i < 9; i++) begin
      sum_all = sum_all + 12'(win_i[i]);
    end
    gauss = 12'(win_i[0]) + 12'(win_i[2]) + 12'(win_i[6]) + 12'(win_i[8])
          + ((12'(win_i[1]) + 12'(win_i[3]) + 12'(win_i[5]) + 12'(win_i[7])) << 1)
          + (12'(win_i[4]) << 2);
    pxp = 10'(win_i[2]) + 10'(win_i[5]) + 10'(win_i[8]);
    pxn = 10'(win_i[0]) + 10'(win_i[3]) + 10'(win_i[6]);
    pyp = 10'(win_i[6]) + 10'(win_i[7]) + 10'(win_i[8]);
    pyn = 10'(win_i[0]) + 10'(win_i[1]) + 10'(win_i[2]);
    sxp = 10'(win_i[2]) + (10'(win_i[5]) << 1) + 10'(win_i[8]);
    sxn = 10'(win_i[0]) + (10'(win_i[3]) << 1) + 10'(win_i[6]);
    syp = 10'(win_i[6]) + (10'(win_i[7]) << 1) + 10'(win_i[8]);
    syn = 10'(win_i[0]) + (10'(win_i[1]) << 1) + 10'(win_i[2]);
    px_abs = abs_diff(12'(pxp), 12'(pxn));
    py_abs = abs_diff(12'(pyp), 12'(pyn));
    sx_abs = abs_diff(12'(sxp), 12'(sxn));
    sy_abs = abs_diff(12'(syp), 12'(syn));
    c9  = (12'(win_i[4]) << 3) + 12'(win_i[4]);
    c10 = (12'(win_i[4]) << 3) + (12'(win_i[4]) << 1);
    lap_abs = abs_diff(c9, sum_all);
    sharp_diff = c10 - sum_all;
    // sharpen clips to 0..255
    if (c10 < sum_all) begin
      sharp = 8'd0;
    end else if (sharp_diff > 12'd255) begin
      sharp = 8'd255;
    end else begin
      sharp = sharp_diff[7:0];
    end
  end

  always_comb begin
    kind3_d = kif_pkg::KIND_PASS;
    val3_d  = '0;
    unique case (mode_i)
      kif_pkg::MODE_BOX: begin
        kind3_d = kif_pkg::KIND_BOX;
        val3_d  = sum_all;
      end
      kif_pkg::MODE_GAUSS:     val3_d = gauss >> 4;
      kif_pkg::MODE_PREWITT_X: begin
        kind3_d = kif_pkg::KIND_DIV3;
        val3_d  = px_abs;
      end
      kif_pkg::MODE_PREWITT_Y: begin
        kind3_d = kif_pkg::KIND_DIV3;
        val3_d  = py_abs;
      end
      kif_pkg::MODE_SOBEL_X:   val3_d = sx_abs >> 2;
      kif_pkg::MODE_SOBEL_Y:   val3_d = sy_abs >> 2;
      kif_pkg::MODE_LAPLACE:   val3_d = lap_abs >> 3;
      kif_pkg::MODE_SHARPEN:   val3_d = 12'(sharp);
    endcase
    // border centres report zero
    if (!win_flags_i.centre_valid) begin
      kind3_d = kif_pkg::KIND_PASS;
      val3_d  = '0;
    end
  end

  always_comb begin
    case (kind3_q)
      kif_pkg::KIND_BOX:  prod4_d = 25'(val3_q) * 25'(kif_pkg::BOX_NUM);
      kif_pkg::KIND_DIV3: prod4_d = 25'(val3_q) * 25'(kif_pkg::DIV3_MUL);
      default:            prod4_d = 25'(val3_q);
    endcase
  end

  assign box_prod = 51'(prod4_q) * 51'(kif_pkg::BOX_RECIP);

  always_comb begin
    case (kind4_q)
      kif_pkg::KIND_BOX:  filt_d = box_prod[kif_pkg::BOX_SHIFT +: 8];
      kif_pkg::KIND_DIV3: filt_d = prod4_q[kif_pkg::DIV3_SHIFT +: 8];
      default:            filt_d = prod4_q[7:0];
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      vo_q <= 1'b0;
    end else begin
      v3_q <= v3_d;
      v4_q <= v4_d;
      vo_q <= vo_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld3 && win_valid_i) begin
      kind3_q <= kind3_d;
      val3_q  <= val3_d;
      fl3_q   <= win_flags_i;
    end
    if (ld4 && v3_q) begin
      kind4_q <= kind3_q;
      prod4_q <= prod4_d;
      fl4_q   <= fl3_q;
    end
    if (ldo && v4_q) begin
      filt_q  <= filt_d;
      flo_q   <= fl4_q;
    end
  end

  assign res_o.valid        = vo_q;
  assign res_o.filtered     = filt_q;
  assign res_o.centre_valid = flo_q.centre_valid;
  assign res_o.frame_done   = flo_q.frame_done;

endmodule

// ----- src/kif_checker.sv -----
`timescale 1ns / 1ps
// kif_checker: port-level assertions for kernel_3x3_image_filter, with its bind.
// Depends on the top level's ports only.

module kif_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_ready_i,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [7:0] filtered_i,
  input logic       centre_valid_i,
  input logic       frame_done_i
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable({filtered_i, centre_valid_i, frame_done_i}))
    else $error("stalled result changed");

  // last pixel of a frame always sits at row >= 2, column >= 2
  a_done_interior: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && frame_done_i |-> centre_valid_i)
    else $error("frame end on a border centre");

  a_border_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !centre_valid_i |-> filtered_i == 8'd0)
    else $error("border centre with nonzero value");

  // an empty output register lets the whole pipe move
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_i |-> in_ready_i)
    else $error("input stalled with empty output");

endmodule

bind kernel_3x3_image_filter kif_checker u_kif_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_ready_i     (pix_i.ready),
  .out_valid_i    (res_o.valid),
  .out_ready_i    (res_o.ready),
  .filtered_i     (res_o.filtered),
  .centre_valid_i (res_o.centre_valid),
  .frame_done_i   (res_o.frame_done)
);
